/* hw/rtl/mqd_pkg.sv */
`default_nettype none

package mqd_pkg;

  localparam int QUEUES     = 8;
  localparam int QIDX_BITS  = 3;
  localparam int QCNT_BITS  = 4;
  localparam int TAG_BITS   = 16;
  localparam int TDATA_BITS = 32;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic [1:0] {
    EV_PLACED  = 2'd0,
    EV_SERVED  = 2'd1,
    EV_DROPPED = 2'd2,
    EV_IDLE    = 2'd3
  } event_t;

  typedef struct packed {
    event_t                 ev;
    logic [QIDX_BITS-1:0]   qidx;
    logic [TAG_BITS-1:0]    tag;
    logic                   opened;
    logic                   closed;
    logic                   all_empty;
    logic [QCNT_BITS-1:0]   in_use;
    logic                   last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/mqd_ram.sv */
`default_nettype none

module mqd_ram #(
  parameter int WORDS = 8,
  parameter int WIDTH = 8,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  // one write port, one registered read port; a read of the entry being
  // written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mqd_out_reg.sv */
`default_nettype none

module mqd_out_reg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire mqd_pkg::result_t                res,
  output logic                                 free,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // queue_index, served_tag, opened, closed, all_empty, queues_in_use, zero pad
  output logic [mqd_pkg::TDATA_BITS-1:0]       m_axis_tdata,
  // event_res
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int FIELD_BITS = mqd_pkg::QIDX_BITS + mqd_pkg::TAG_BITS + 3
                              + mqd_pkg::QCNT_BITS;

  mqd_pkg::result_t res_r;

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (load) begin
      res_r <= res;
    end
  end

  assign m_axis_tdata = {{(mqd_pkg::TDATA_BITS - FIELD_BITS){1'b0}},
                         res_r.in_use, res_r.all_empty, res_r.closed,
                         res_r.opened, res_r.tag, res_r.qidx};
  assign m_axis_tuser = res_r.ev;
  assign m_axis_tlast = res_r.last;

endmodule

`default_nettype wire

/* hw/rtl/multi_queue_dispatcher.sv */
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   tuser[0] operation, tdata[15:0] customer_tag
// m_axis    out  tuser[1:0] event_res, tdata queue fields, tlast on final beat
//
// Arrival: accept with queue state read, then tag write and result.
// Dropped arrival and idle tick: accept, then result. Tick: for each queue served,
// a queue state RAM read followed by a tag RAM read, then its result beat.
// Reset clears the created count and the per-queue busy/full flags at once; the
// RAMs need no clearing pass, a queue's state word is written on its first placement.
// A result waiting on m_axis does not stop the next beat being accepted; the FSM
// stalls only when it must load a result into an occupied output register.
module multi_queue_dispatcher #(
  parameter int DEPTH = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // customer_tag
  input  wire logic [15:0]                   s_axis_tdata,
  // operation
  input  wire logic [0:0]                    s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // queue_index[2:0], served_tag[18:3], opened[19], closed[20], all_empty[21],
  // queues_in_use[25:22], zero[31:26]
  output logic [mqd_pkg::TDATA_BITS-1:0]     m_axis_tdata,
  // event_res
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int QUEUES = mqd_pkg::QUEUES;
  localparam int QW     = mqd_pkg::QIDX_BITS;
  localparam int CW     = mqd_pkg::QCNT_BITS;
  localparam int TW     = mqd_pkg::TAG_BITS;
  localparam int HW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW     = $clog2(DEPTH + 1);
  localparam int SW     = HW + FW;
  localparam int SUMW   = ((HW > FW) ? HW : FW) + 1;
  localparam int TAW    = $clog2(QUEUES * DEPTH);

  localparam logic [HW-1:0]     HEAD_LAST = HW'(DEPTH - 1);
  localparam logic [FW-1:0]     DEPTH_F   = FW'(DEPTH);
  localparam logic [FW-1:0]     FILL_ONE  = FW'(1);
  localparam logic [SUMW-1:0]   DEPTH_S   = SUMW'(DEPTH);
  localparam logic [TAW-1:0]    DEPTH_A   = TAW'(DEPTH);
  localparam logic [CW-1:0]     QUEUES_C  = CW'(QUEUES);
  localparam logic [QUEUES-1:0] ONE_Q     = QUEUES'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AWR,
    S_EMIT,
    S_TADR,
    S_TOUT
  } state_t;

  function automatic logic [QW-1:0] first_set(input logic [QUEUES-1:0] v);
    logic [QW-1:0] idx;
    idx = '0;
    for (int i = QUEUES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = QW'(i);
      end
    end
    return idx;
  endfunction

  state_t                state;
  logic [QW-1:0]         cur_q;
  logic [TW-1:0]         cur_tag;
  logic                  new_q;
  logic [QUEUES-1:0]     pending;
  mqd_pkg::event_t       ev_hold;
  logic                  t_closed;
  logic                  t_last;
  logic [CW-1:0]         created_count;
  logic [QUEUES-1:0]     nonempty;
  logic [QUEUES-1:0]     full;

  logic [QUEUES-1:0]     created_mask;
  logic [QUEUES-1:0]     avail;
  logic [QUEUES-1:0]     empt;
  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  mqd_pkg::result_t      res;
  logic                  any_busy;

  logic                  sr_re;
  logic [QW-1:0]         sr_raddr;
  logic                  sr_we;
  logic [SW-1:0]         sr_wdata;
  logic [SW-1:0]         sr_rdata;
  logic [HW-1:0]         sr_head;
  logic [FW-1:0]         sr_fill;
  logic [HW-1:0]         head_eff;
  logic [FW-1:0]         fill_eff;
  logic [FW-1:0]         fill_inc;
  logic [SUMW-1:0]       pos_sum;
  logic [HW-1:0]         tail_pos;
  logic [HW-1:0]         head_adv;
  logic [TAW-1:0]        q_base;

  logic                  tr_we;
  logic [TAW-1:0]        tr_waddr;
  logic                  tr_re;
  logic [TAW-1:0]        tr_raddr;
  logic [TW-1:0]         tr_rdata;

  always_comb begin
    for (int q = 0; q < QUEUES; q++) begin
      created_mask[q] = (CW'(q) < created_count);
    end
  end

  assign avail    = nonempty & ~full;
  assign empt     = created_mask & ~nonempty;
  assign any_busy = |nonempty;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // queue state word: head pointer above fill count
  assign sr_head  = sr_rdata[SW-1:FW];
  assign sr_fill  = sr_rdata[FW-1:0];
  assign head_eff = new_q ? '0 : sr_head;
  assign fill_eff = new_q ? '0 : sr_fill;
  assign fill_inc = fill_eff + FILL_ONE;
  assign pos_sum  = SUMW'(head_eff) + SUMW'(fill_eff);
  assign tail_pos = (pos_sum >= DEPTH_S) ? HW'(pos_sum - DEPTH_S) : HW'(pos_sum);
  assign head_adv = (sr_head == HEAD_LAST) ? '0 : sr_head + HW'(1);
  assign q_base   = TAW'(cur_q) * DEPTH_A;

  // RAM ports and result assembly
  always_comb begin
    sr_re    = 1'b0;
    sr_raddr = first_set(nonempty);
    sr_we    = 1'b0;
    sr_wdata = {head_eff, fill_inc};
    tr_we    = 1'b0;
    tr_waddr = q_base + TAW'(tail_pos);
    tr_re    = 1'b0;
    tr_raddr = q_base + TAW'(sr_head);
    out_load = 1'b0;
    res      = '{ev: mqd_pkg::EV_PLACED, qidx: cur_q, tag: cur_tag, opened: 1'b0,
                 closed: 1'b0, all_empty: 1'b0, in_use: created_count, last: 1'b1};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          sr_re = 1'b1;
          if (s_axis_tuser[0] == mqd_pkg::OP_ARRIVE) begin
            sr_raddr = (|avail) ? first_set(avail) : first_set(empt);
          end
        end
      end
      S_AWR: begin
        if (out_free) begin
          sr_we      = 1'b1;
          tr_we      = 1'b1;
          out_load   = 1'b1;
          res.opened = (fill_eff == '0);
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          res.ev        = ev_hold;
          res.qidx      = '0;
          res.tag       = (ev_hold == mqd_pkg::EV_DROPPED) ? cur_tag : '0;
          res.all_empty = (created_count != '0) && !any_busy;
        end
      end
      S_TADR: begin
        sr_we    = 1'b1;
        sr_wdata = {head_adv, sr_fill - FILL_ONE};
        tr_re    = 1'b1;
      end
      S_TOUT: begin
        if (out_free) begin
          out_load      = 1'b1;
          res.ev        = mqd_pkg::EV_SERVED;
          res.tag       = tr_rdata;
          res.closed    = t_closed;
          res.all_empty = (created_count != '0) && !any_busy;
          res.last      = t_last;
          if (!t_last) begin
            sr_re    = 1'b1;
            sr_raddr = first_set(pending);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      created_count <= '0;
      nonempty      <= '0;
      full          <= '0;
      pending       <= '0;
      new_q         <= 1'b0;
      t_last        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur_tag <= s_axis_tdata[TW-1:0];
            if (s_axis_tuser[0] == mqd_pkg::OP_ARRIVE) begin
              if (|avail) begin
                cur_q <= first_set(avail);
                new_q <= 1'b0;
                state <= S_AWR;
              end else if (|empt) begin
                cur_q <= first_set(empt);
                new_q <= 1'b0;
                state <= S_AWR;
              end else if (created_count < QUEUES_C) begin
                // open a fresh queue; its state word is written on placement
                cur_q         <= QW'(created_count);
                new_q         <= 1'b1;
                created_count <= created_count + CW'(1);
                state         <= S_AWR;
              end else begin
                ev_hold <= mqd_pkg::EV_DROPPED;
                state   <= S_EMIT;
              end
            end else if (any_busy) begin
              cur_q   <= first_set(nonempty);
              pending <= nonempty & ~(ONE_Q << first_set(nonempty));
              state   <= S_TADR;
            end else begin
              ev_hold <= mqd_pkg::EV_IDLE;
              state   <= S_EMIT;
            end
          end
        end
        S_AWR: begin
          if (out_free) begin
            nonempty[cur_q] <= 1'b1;
            full[cur_q]     <= (fill_inc == DEPTH_F);
            state           <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_TADR: begin
          // pop the head: flags follow the new fill count
          nonempty[cur_q] <= (sr_fill != FILL_ONE);
          full[cur_q]     <= 1'b0;
          t_closed        <= (sr_fill == FILL_ONE);
          t_last          <= (pending == '0);
          state           <= S_TOUT;
        end
        S_TOUT: begin
          if (out_free) begin
            if (t_last) begin
              state <= S_IDLE;
            end else begin
              cur_q   <= first_set(pending);
              pending <= pending & ~(ONE_Q << first_set(pending));
              state   <= S_TADR;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  mqd_ram #(
    .WORDS (QUEUES),
    .WIDTH (SW)
  ) u_state_ram (
    .clk   (clk),
    .we    (sr_we),
    .waddr (cur_q),
    .wdata (sr_wdata),
    .re    (sr_re),
    .raddr (sr_raddr),
    .rdata (sr_rdata)
  );

  mqd_ram #(
    .WORDS (QUEUES * DEPTH),
    .WIDTH (TW)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tr_we),
    .waddr (tr_waddr),
    .wdata (cur_tag),
    .re    (tr_re),
    .raddr (tr_raddr),
    .rdata (tr_rdata)
  );

  mqd_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (out_load),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_full_implies_busy: assert property (@(posedge clk) disable iff (rst)
    (full & ~nonempty) == '0)
    else $error("queue flagged full while empty");

  a_busy_only_created: assert property (@(posedge clk) disable iff (rst)
    (nonempty & ~created_mask) == '0)
    else $error("uncreated queue holds tags");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    created_count <= QUEUES_C)
    else $error("created count past queue limit");

  a_drop_when_all_created: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == mqd_pkg::EV_DROPPED) |-> created_count == QUEUES_C)
    else $error("drop reported with a queue still free to create");
`endif

endmodule

`default_nettype wire
